@@ rtl/sam_pkg.sv @@
// sam_pkg: operation and fault codes, the queued command type and the
// saturating Q32.32 helpers used by the back of the stack machine
// depends on nothing
package sam_pkg;

	localparam logic [2:0] OP_ADD  = 3'd0;
	localparam logic [2:0] OP_SUB  = 3'd1;
	localparam logic [2:0] OP_MUL  = 3'd2;
	localparam logic [2:0] OP_DIV  = 3'd3;
	localparam logic [2:0] OP_NEG  = 3'd4;
	localparam logic [2:0] OP_PUSH = 3'd5;
	localparam logic [2:0] OP_EXIT = 3'd6;

	localparam logic [1:0] FLT_NONE  = 2'd0;
	localparam logic [1:0] FLT_UNDER = 2'd1;
	localparam logic [1:0] FLT_OVER  = 2'd2;
	localparam logic [1:0] FLT_DIV0  = 2'd3;

	localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic [2:0]  op;
		logic [63:0] cval;
		logic [1:0]  need;     // entries the operation must find on the stack
		logic        is_push;
	} cmd_t;

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		if (a[63] == b[63] && s[63] != a[63])
			return a[63] ? Q_MIN : Q_MAX;
		return s;
	endfunction

	function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] d;
		d = a - b;
		if (a[63] != b[63] && d[63] != a[63])
			return a[63] ? Q_MIN : Q_MAX;
		return d;
	endfunction

	function automatic logic [63:0] from_mag(input logic neg, input logic [63:0] mag,
			input logic big);
		if (!neg)
			return (big || mag > Q_MAX) ? Q_MAX : mag;
		if (big || mag > Q_MIN)
			return Q_MIN;
		return 64'd0 - mag;
	endfunction

	function automatic logic [63:0] magnitude(input logic [63:0] x);
		return x[63] ? (64'd0 - x) : x;
	endfunction

endpackage

@@ rtl/sam_front.sv @@
// sam_front: accepts instruction beats and classifies them into queue commands
// depends on sam_pkg
module sam_front (
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [2:0]    operation,
	input  logic [63:0]   constant_value,
	input  logic          q_full,
	output logic          q_push,
	output sam_pkg::cmd_t q_cmd
);
	import sam_pkg::*;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_cmd.op      = operation;
		q_cmd.cval    = constant_value;
		q_cmd.is_push = (operation == OP_PUSH);
		case (operation)
			OP_ADD, OP_SUB, OP_MUL, OP_DIV: q_cmd.need = 2'd2;
			OP_NEG, OP_EXIT:                q_cmd.need = 2'd1;
			default:                        q_cmd.need = 2'd0;
		endcase
	end
endmodule

@@ rtl/sam_queue.sv @@
// sam_queue: two-entry command queue between front and back
// depends on sam_pkg
module sam_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sam_pkg::cmd_t wr_cmd,
	output logic          full,
	output logic          nonempty,
	input  logic          pop,
	output sam_pkg::cmd_t rd_cmd
);
	import sam_pkg::*;

	cmd_t       slot_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign nonempty = (cnt_q != 2'd0);
	assign rd_cmd   = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wp_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (pop)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

@@ rtl/sam_back.sv @@
// sam_back: executes queued commands on the operand stack, top entry in a
// register, the rest in a memory; shared multiply and divide sequencers
// depends on sam_pkg
module sam_back #(
	parameter int STACK_DEPTH = 256,
	parameter int SP_W = $clog2(STACK_DEPTH + 1),
	parameter int AW = $clog2(STACK_DEPTH)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_nonempty,
	input  sam_pkg::cmd_t   q_cmd,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [63:0]     top_value,
	output logic [SP_W-1:0] stack_depth,
	output logic            exited,
	output logic [63:0]     exit_value,
	output logic [1:0]      fault
);
	import sam_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]      st_q;
	logic [SP_W-1:0] sp_q;
	logic [63:0]     top_q;
	cmd_t            cmd_q;
	logic [63:0]     mem [STACK_DEPTH];
	logic [63:0]     rd_q;
	logic            wr_en;
	logic [AW-1:0]   wr_addr, rd_addr;

	logic [1:0]      flt_q;
	logic            ex_q;
	logic [63:0]     exv_q;

	// multiply and divide working registers
	logic            neg_q, big_q;
	logic [63:0]     xm_q, ym_q, quo_q, rem_q;
	logic [127:0]    acc_q, num_q;
	logic [63:0]     prod_q;
	logic [6:0]      cnt_q;
	logic [63:0]     rs;
	logic            ge;

	// classification of the command being executed
	logic            under, div_zero, over, is_exit;

	logic out_free;
	assign out_free = !out_valid || !out_stall;
	assign q_pop    = (st_q == S_IDLE) && q_nonempty;

	assign under    = sp_q < SP_W'(cmd_q.need);
	assign div_zero = (cmd_q.op == OP_DIV) && (top_q == 64'd0);
	assign over     = cmd_q.is_push && (sp_q == SP_W'(STACK_DEPTH));
	assign is_exit  = !under && (cmd_q.op == OP_EXIT);

	assign rd_addr = sp_q[AW-1:0] - AW'(2);
	assign wr_addr = sp_q[AW-1:0] - AW'(1);
	assign wr_en   = (st_q == S_EXEC) && cmd_q.is_push && sp_q != SP_W'(STACK_DEPTH)
		&& sp_q != '0;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= top_q;
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
	end

	assign rs = {rem_q[62:0], num_q[127]};
	assign ge = (rs >= ym_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			sp_q      <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall && st_q != S_DONE)
				out_valid <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (q_nonempty) begin
						cmd_q <= q_cmd;
						st_q  <= S_EXEC;
					end
				end
				S_EXEC: begin
					neg_q <= rd_q[63] != top_q[63];
					xm_q  <= magnitude(rd_q);
					ym_q  <= magnitude(top_q);
					ex_q  <= is_exit;
					exv_q <= is_exit ? top_q : 64'd0;
					if (under)
						flt_q <= FLT_UNDER;
					else if (div_zero)
						flt_q <= FLT_DIV0;
					else if (over)
						flt_q <= FLT_OVER;
					else
						flt_q <= FLT_NONE;
					if (!under && cmd_q.op == OP_MUL)
						st_q <= S_MUL;
					else if (!under && cmd_q.op == OP_DIV && !div_zero)
						st_q <= S_DIV;
					else
						st_q <= S_DONE;
					if (!under) begin
						case (cmd_q.op)
							OP_ADD: begin
								top_q <= sat_add(rd_q, top_q);
								sp_q  <= sp_q - SP_W'(1);
							end
							OP_SUB: begin
								top_q <= sat_sub(rd_q, top_q);
								sp_q  <= sp_q - SP_W'(1);
							end
							OP_MUL: begin
								acc_q <= '0;
								cnt_q <= '0;
							end
							OP_DIV: begin
								if (div_zero) begin
									top_q <= (rd_q == 64'd0) ? 64'd0 : (rd_q[63] ? Q_MIN : Q_MAX);
									sp_q  <= sp_q - SP_W'(1);
								end else begin
									num_q <= {32'd0, magnitude(rd_q), 32'd0};
									rem_q <= '0;
									quo_q <= '0;
									big_q <= 1'b0;
									cnt_q <= '0;
								end
							end
							OP_NEG: top_q <= sat_sub(64'd0, top_q);
							OP_PUSH: begin
								if (!over) begin
									top_q <= cmd_q.cval;
									sp_q  <= sp_q + SP_W'(1);
								end
							end
							OP_EXIT: begin
								top_q <= rd_q;
								sp_q  <= sp_q - SP_W'(1);
							end
							default: ;
						endcase
					end
				end
				S_MUL: begin
					// four 32x32 partial products, each registered and accumulated in the next cycle
					cnt_q <= cnt_q + 7'd1;
					case (cnt_q)
						7'd0: prod_q <= xm_q[31:0] * ym_q[31:0];
						7'd1: begin
							acc_q  <= acc_q + {64'd0, prod_q};
							prod_q <= xm_q[31:0] * ym_q[63:32];
						end
						7'd2: begin
							acc_q  <= acc_q + {32'd0, prod_q, 32'd0};
							prod_q <= xm_q[63:32] * ym_q[31:0];
						end
						7'd3: begin
							acc_q  <= acc_q + {32'd0, prod_q, 32'd0};
							prod_q <= xm_q[63:32] * ym_q[63:32];
						end
						7'd4: acc_q <= acc_q + {prod_q, 64'd0};
						default: begin
							quo_q <= acc_q[95:32];
							big_q <= |acc_q[127:96];
							st_q  <= S_FIN;
						end
					endcase
				end
				S_DIV: begin
					// restoring division, one quotient bit a cycle
					num_q <= {num_q[126:0], 1'b0};
					rem_q <= ge ? (rs - ym_q) : rs;
					quo_q <= {quo_q[62:0], ge};
					if (!cnt_q[6] && ge)
						big_q <= 1'b1;
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd127)
						st_q <= S_FIN;
				end
				S_FIN: begin
					top_q <= from_mag(neg_q, quo_q, big_q);
					sp_q  <= sp_q - SP_W'(1);
					st_q  <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid   <= 1'b1;
						top_value   <= (sp_q != '0) ? top_q : 64'd0;
						stack_depth <= sp_q;
						exited      <= ex_q;
						exit_value  <= exv_q;
						fault       <= flt_q;
						st_q        <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/stack_arithmetic_machine.sv @@
// stack_arithmetic_machine: top level of the Q32.32 stack calculator
// depends on sam_pkg, sam_front, sam_queue, sam_back
//
// One instruction beat in, one result beat out. A two-entry queue lets the
// input take beats while the executing back end works. Add, subtract, negate,
// push, exit and any faulting instruction finish in the back end's execute
// step; multiply forms four 32x32 partial products on one multiplier; divide
// runs a restoring divider, one quotient bit a cycle. The top entry
// lives in a register, the rest of the stack in a memory of STACK_DEPTH
// words with one write port and one registered read port. Values saturate;
// faults go out in the result beat; only divide by zero alters the stack.
module stack_arithmetic_machine #(
	parameter int STACK_DEPTH = 256
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [2:0]                         operation,
	input  logic [63:0]                        constant_value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [63:0]                        top_value,
	output logic [$clog2(STACK_DEPTH + 1)-1:0] stack_depth,
	output logic                               exited,
	output logic [63:0]                        exit_value,
	output logic [1:0]                         fault
);
	import sam_pkg::*;

	localparam int SP_W = $clog2(STACK_DEPTH + 1);

	cmd_t wr_cmd, rd_cmd;
	logic q_push, q_pop, q_full, q_nonempty;

	sam_front u_front (
		.in_valid, .in_stall, .operation, .constant_value,
		.q_full, .q_push, .q_cmd(wr_cmd)
	);

	sam_queue u_queue (
		.clk, .arst_n, .push(q_push), .wr_cmd, .full(q_full),
		.nonempty(q_nonempty), .pop(q_pop), .rd_cmd
	);

	sam_back #(.STACK_DEPTH(STACK_DEPTH), .SP_W(SP_W)) u_back (
		.clk, .arst_n, .q_nonempty, .q_cmd(rd_cmd), .q_pop,
		.out_valid, .out_stall, .top_value, .stack_depth,
		.exited, .exit_value, .fault
	);
endmodule

@@ rtl/sam_checker.sv @@
// sam_checker: port-level assertions for the stack machine, bound to the top
// depends on sam_pkg
module sam_checker #(
	parameter int STACK_DEPTH = 256,
	parameter int SP_W = $clog2(STACK_DEPTH + 1)
) (
	input logic            clk,
	input logic            arst_n,
	input logic            out_valid,
	input logic            out_stall,
	input logic [63:0]     top_value,
	input logic [SP_W-1:0] stack_depth,
	input logic            exited,
	input logic [63:0]     exit_value,
	input logic [1:0]      fault
);
	import sam_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(top_value) && $stable(fault))
		else $error("result changed while stalled");

	a_exit_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && exited |-> fault == FLT_NONE)
		else $error("exit with fault");

	a_exit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !exited |-> exit_value == 64'd0)
		else $error("exit value without exit");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stack_depth == '0 |-> top_value == 64'd0)
		else $error("empty stack with nonzero top");

	a_over_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault == FLT_OVER |-> stack_depth == SP_W'(STACK_DEPTH))
		else $error("overflow on a stack that is not full");
endmodule

bind stack_arithmetic_machine sam_checker #(.STACK_DEPTH(STACK_DEPTH), .SP_W(SP_W)) u_chk (
	.clk, .arst_n, .out_valid, .out_stall, .top_value, .stack_depth,
	.exited, .exit_value, .fault
);

@@ tb/stack_arithmetic_machine_test.sv @@
// stack_arithmetic_machine_test: self-checking bench for the Q32.32 stack calculator
// depends on sam_pkg and stack_arithmetic_machine; a directed table then random
// instruction streams, each result beat checked against its table entry or a local stack predictor
module stack_arithmetic_machine_test;
	timeunit 1ns;
	timeprecision 1ps;
	import sam_pkg::*;

	localparam int DEPTH = 256;
	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam int N_RANDOM = 1130;
	localparam int N_CALM = 150;

	typedef struct {
		logic [63:0] top;
		logic [8:0]  depth;
		logic        ex;
		logic [63:0] exv;
		logic [1:0]  flt;
	} result_t;

	typedef struct {
		logic [2:0]  op;
		logic [63:0] cval;
		bit          typed;
		result_t     res;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  operation = OP_ADD;
	logic [63:0] constant_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] top_value;
	logic [8:0]  stack_depth;
	logic        exited;
	logic [63:0] exit_value;
	logic [1:0]  fault;

	logic [63:0] calc_stack [DEPTH];
	int          calc_sp = 0;
	result_t     pending_results [$];
	int          errors = 0;
	int          beats_in = 0, beats_out = 0, n_faults = 0, n_exits = 0, peak_depth = 0;
	bit          calm = 1'b0;

	stack_arithmetic_machine u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .constant_value(constant_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.top_value(top_value), .stack_depth(stack_depth),
		.exited(exited), .exit_value(exit_value), .fault(fault)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#50ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [63:0] clamp(input bit neg, input logic [63:0] mag, input bit big);
		if (!neg)
			return (big || mag[63]) ? Q_MAX : mag;
		if (big || mag > Q_MIN)
			return Q_MIN;
		return -mag;
	endfunction

	function automatic logic [63:0] q_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? Q_MIN : Q_MAX;
		return s[63:0];
	endfunction

	function automatic logic [63:0] q_sub(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] d;
		d = {a[63], a} - {b[63], b};
		if (d[64] != d[63])
			return d[64] ? Q_MIN : Q_MAX;
		return d[63:0];
	endfunction

	function automatic logic [63:0] q_mul(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		logic [63:0] x, y;
		x = a[63] ? -a : a;
		y = b[63] ? -b : b;
		p = {64'd0, x} * {64'd0, y};
		return clamp(a[63] ^ b[63], p[95:32], |p[127:96]);
	endfunction

	function automatic logic [63:0] q_div(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] q;
		logic [63:0] x, y;
		x = a[63] ? -a : a;
		y = b[63] ? -b : b;
		q = {32'd0, x, 32'd0} / {64'd0, y};
		return clamp(a[63] ^ b[63], q[63:0], |q[127:64]);
	endfunction

	// advance the local stack by one instruction and return the beat it should give
	function automatic result_t apply_instruction(input logic [2:0] op, input logic [63:0] cv);
		result_t r;
		logic [63:0] a, b, v;
		r.ex = 1'b0;
		r.exv = '0;
		r.flt = FLT_NONE;
		case (op)
			OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
				if (calc_sp < 2) r.flt = FLT_UNDER;
				else begin
					b = calc_stack[calc_sp-1];
					a = calc_stack[calc_sp-2];
					case (op)
						OP_ADD: v = q_add(a, b);
						OP_SUB: v = q_sub(a, b);
						OP_MUL: v = q_mul(a, b);
						default: begin
							if (b == 0) begin
								r.flt = FLT_DIV0;
								v = (a == 0) ? 64'd0 : (a[63] ? Q_MIN : Q_MAX);
							end else v = q_div(a, b);
						end
					endcase
					calc_sp--;
					calc_stack[calc_sp-1] = v;
				end
			end
			OP_NEG: begin
				if (calc_sp < 1) r.flt = FLT_UNDER;
				else calc_stack[calc_sp-1] = q_sub(64'd0, calc_stack[calc_sp-1]);
			end
			OP_PUSH: begin
				if (calc_sp >= DEPTH) r.flt = FLT_OVER;
				else begin
					calc_stack[calc_sp] = cv;
					calc_sp++;
				end
			end
			OP_EXIT: begin
				if (calc_sp < 1) r.flt = FLT_UNDER;
				else begin
					calc_sp--;
					r.exv = calc_stack[calc_sp];
					r.ex = 1'b1;
				end
			end
			default: ;
		endcase
		r.top = (calc_sp > 0) ? calc_stack[calc_sp-1] : 64'd0;
		r.depth = calc_sp[8:0];
		return r;
	endfunction

	function automatic logic [63:0] rand_q();
		case ($urandom_range(0, 7))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return 64'd0;
			3, 4: return {{32{1'b0}}, 32'($urandom_range(0, 40))} << 32
				^ ($urandom_range(0, 1) ? 64'hFFFF_FFFF_0000_0000 : 64'd0);
			5: return {{32{1'b0}}, $urandom};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send(input logic [2:0] op, input logic [63:0] cv, input bit typed,
			input result_t typed_res);
		result_t r;
		operation <= op;
		constant_value <= cv;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		r = apply_instruction(op, cv);
		pending_results.push_back(typed ? typed_res : r);
		beats_in++;
		if (calc_sp > peak_depth) peak_depth = calc_sp;
		@(negedge clk);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
	endtask

	task automatic send_plain(input logic [2:0] op, input logic [63:0] cv);
		result_t none;
		send(op, cv, 1'b0, none);
	endtask

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing outstanding");
				errors++;
			end else begin
				result_t e;
				e = pending_results.pop_front();
				check_field("top_value", e.top, top_value);
				check_field("stack_depth", 64'(e.depth), 64'(stack_depth));
				check_field("exited", 64'(e.ex), 64'(exited));
				check_field("exit_value", e.exv, exit_value);
				check_field("fault", 64'(e.flt), 64'(fault));
				if (e.flt != FLT_NONE) n_faults++;
				if (e.ex) n_exits++;
				beats_out++;
			end
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	function automatic result_t rs(input logic [63:0] t, input int d, input logic [1:0] f,
			input bit e = 0, input logic [63:0] ev = 0);
		result_t r;
		r.top = t;
		r.depth = d[8:0];
		r.flt = f;
		r.ex = e;
		r.exv = ev;
		return r;
	endfunction

	initial begin
		row_t tbl [$];
		row_t rw;
		result_t none;
		logic [2:0] op;
		int roll;

		// typed rows: empty-stack faults, extremes, saturation, divide by zero, an unused opcode and exit
		tbl.push_back('{OP_EXIT, '0, 1, rs(0, 0, FLT_UNDER)});
		tbl.push_back('{OP_ADD, '0, 1, rs(0, 0, FLT_UNDER)});
		tbl.push_back('{OP_NEG, '0, 1, rs(0, 0, FLT_UNDER)});
		tbl.push_back('{OP_PUSH, Q_MIN, 1, rs(Q_MIN, 1, FLT_NONE)});
		tbl.push_back('{OP_DIV, '0, 1, rs(Q_MIN, 1, FLT_UNDER)});
		tbl.push_back('{OP_NEG, '0, 1, rs(Q_MAX, 1, FLT_NONE)});
		tbl.push_back('{OP_PUSH, Q_MAX, 1, rs(Q_MAX, 2, FLT_NONE)});
		tbl.push_back('{OP_ADD, '0, 1, rs(Q_MAX, 1, FLT_NONE)});
		tbl.push_back('{OP_PUSH, 64'd0, 1, rs(0, 2, FLT_NONE)});
		tbl.push_back('{OP_DIV, '0, 1, rs(Q_MAX, 1, FLT_DIV0)});
		tbl.push_back('{OP_PUSH, 64'd0, 1, rs(0, 2, FLT_NONE)});
		tbl.push_back('{OP_DIV, '0, 1, rs(Q_MAX, 1, FLT_DIV0)});
		tbl.push_back('{OP_UNUSED, '1, 1, rs(Q_MAX, 1, FLT_NONE)});
		tbl.push_back('{OP_EXIT, '0, 1, rs(0, 0, FLT_NONE, 1, Q_MAX)});
		// remaining rows go through the predictor
		tbl.push_back('{OP_PUSH, 64'h0000_0003_0000_0000, 0, none});
		tbl.push_back('{OP_PUSH, 64'h0000_0002_8000_0000, 0, none});
		tbl.push_back('{OP_SUB, '0, 0, none});
		tbl.push_back('{OP_PUSH, 64'hFFFF_FFFF_FFFF_FFFF, 0, none});
		tbl.push_back('{OP_MUL, '0, 0, none});
		tbl.push_back('{OP_PUSH, 64'hFFFF_FFFD_0000_0000, 0, none});
		tbl.push_back('{OP_DIV, '0, 0, none});
		tbl.push_back('{OP_PUSH, Q_MIN, 0, none});
		tbl.push_back('{OP_PUSH, 64'd0, 0, none});
		tbl.push_back('{OP_DIV, '0, 0, none});
		tbl.push_back('{OP_MUL, '0, 0, none});

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (tbl[i]) send(tbl[i].op, tbl[i].cval, tbl[i].typed, tbl[i].res);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM - N_CALM) calm = 1'b1;
			if (n == 300) begin
				// hold off until the machine has drained
				in_valid <= 1'b0;
				while (pending_results.size() != 0) @(negedge clk);
			end
			if (n == 500) begin
				// run up to a full stack and push past it, then unwind
				while (calc_sp < DEPTH) begin
					send_plain(OP_PUSH, rand_q());
					n++;
				end
				repeat (3) send_plain(OP_PUSH, rand_q());
				n += 3;
			end
			roll = $urandom_range(0, 99);
			if (roll < 4) op = 3'($urandom_range(0, 7));
			else if (calc_sp < 2 && roll < 70) op = OP_PUSH;
			else if (calc_sp > 24 && roll < 60) op = ($urandom_range(0, 1)) ? OP_EXIT : OP_ADD;
			else if (roll < 40) op = OP_PUSH;
			else if (roll < 50) op = OP_ADD;
			else if (roll < 60) op = OP_SUB;
			else if (roll < 70) op = OP_MUL;
			else if (roll < 78) op = OP_DIV;
			else if (roll < 86) op = OP_NEG;
			else op = OP_EXIT;
			send_plain(op, rand_q());
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0) @(negedge clk);
		repeat (200) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			errors++;
		end
		$display("%0d instructions in, %0d results checked, %0d faults, %0d exits",
			beats_in, beats_out, n_faults, n_exits);
		$display("stack reached depth %0d, overflow and underflow both exercised", peak_depth);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/sam_pkg.sv
rtl/sam_front.sv
rtl/sam_queue.sv
rtl/sam_back.sv
rtl/stack_arithmetic_machine.sv
rtl/sam_checker.sv
tb/stack_arithmetic_machine_test.sv
